// File: hdl/svpd_pkg.sv
// ============================================================================
// svpd_pkg: shared types and constants for the space vector duty block
// Angle table, fixed-point constants, sector bases and the pipeline item.
// ============================================================================
package svpd_pkg;

  // widths
  localparam int unsigned DataW   = 16;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned DivBits = 16;
  localparam int unsigned RemW    = 31;
  localparam int unsigned Lanes   = 4;
  localparam int unsigned TabLen  = 24;

  localparam int unsigned CordicStepsDef = 16;

  // register indexes
  localparam logic RegSupply = 1'b0;
  localparam logic RegLimit  = 1'b1;

  localparam logic [CfgW-1:0] SupplyRst = 15'd16384;
  localparam logic [CfgW-1:0] LimitRst  = 15'd5120;

  // fixed-point constants, Q30
  localparam logic [29:0]        InvkQ30        = 30'd652032874;
  localparam logic signed [31:0] ThreeHalvesQ30 = 32'sd1610612736;
  localparam logic signed [31:0] HalfSqrt3Q30   = 32'sd929887697;
  localparam logic signed [31:0] Sqrt3Q30       = 32'sd1859775393;

  localparam logic [15:0] DutyMid = 16'd32768;
  localparam logic [15:0] DutyMax = 16'hFFFF;

  // atan(2^-i) as a fraction of one turn, 2^32 = one turn
  localparam logic [31:0] AtanTurn [TabLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // ceil(s * 2^32 / 6), start of each sector in turn units
  localparam logic [31:0] SecBase [8] = '{
    32'd0, 32'd715827883, 32'd1431655766, 32'd2147483648,
    32'd2863311531, 32'd3579139414, 32'd0, 32'd0
  };

  typedef enum logic {
    CORDIC_VECTOR,
    CORDIC_ROTATE
  } cordic_mode_e;

  // one item travelling down the pipeline
  typedef struct packed {
    logic                     simple;
    logic signed [15:0]       q;
    logic [15:0]              angle;
    logic signed [33:0]       cx;
    logic signed [33:0]       cy;
    logic signed [32:0]       cz;
    logic [31:0]              theta;
    logic [2:0]               sec;
    logic signed [30:0]       r;
    logic [2:0][63:0]         prod;
    logic [2:0][33:0]         k;
    logic [2:0]               neg;
    logic [Lanes-1:0][RemW-1:0]    rem;
    logic [Lanes-1:0][DivBits-1:0] quo;
    logic [Lanes-1:0]         ovf;
  } item_t;

endpackage

// File: hdl/svpd_cordic_cell.sv
// ============================================================================
// svpd_cordic_cell: one registered CORDIC micro-rotation
// Vectoring mode drives y to zero, rotation mode drives z to zero.
// ============================================================================
module svpd_cordic_cell import svpd_pkg::*; #(
  parameter cordic_mode_e MODE = CORDIC_VECTOR,
  parameter int unsigned  STEP = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  item_t item_i,
  output item_t item_o
);

  item_t item_d, item_q;

  logic signed [33:0] dx, dy;
  logic signed [32:0] at;
  logic               turn_neg;

  // micro-rotation, direction from sign of y or z
  always_comb begin
    dx = item_i.cy >>> STEP;
    dy = item_i.cx >>> STEP;
    at = $signed({1'b0, AtanTurn[STEP]});
    turn_neg = (MODE == CORDIC_VECTOR) ? item_i.cy[33] : !item_i.cz[32];
    item_d = item_i;
    if (turn_neg) begin
      item_d.cx = item_i.cx - dx;
      item_d.cy = item_i.cy + dy;
      item_d.cz = item_i.cz - at;
    end else begin
      item_d.cx = item_i.cx + dx;
      item_d.cy = item_i.cy - dy;
      item_d.cz = item_i.cz + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: hdl/svpd_div_cell.sv
// ============================================================================
// svpd_div_cell: one registered restoring division step
// Resolves one quotient bit in each of the four lanes.
// ============================================================================
module svpd_div_cell import svpd_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [CfgW-1:0] limit_i,
  input  logic [CfgW-1:0] supply_i,
  input  item_t           item_i,
  output item_t           item_o
);

  item_t item_d, item_q;

  logic [RemW-1:0] sh [Lanes];

  // compare and subtract per lane; phases divide by limit, bound by supply
  always_comb begin
    item_d = item_i;
    for (int l = 0; l < Lanes; l++) begin
      sh[l] = (l < 3) ? (RemW'(limit_i) << BIT) : (RemW'(supply_i) << BIT);
      if (item_i.rem[l] >= sh[l]) begin
        item_d.rem[l]      = item_i.rem[l] - sh[l];
        item_d.quo[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: hdl/space_vector_phase_duty.sv
// ============================================================================
// space_vector_phase_duty: three-phase space vector duty generator
// Turns a (q, d) command and an angle into three saturated phase duties.
// ============================================================================
//
//  channel      dir  transfer payload
//  s_axis       in   volt_q, volt_d, elec_angle
//  m_axis       out  duty_a, duty_b, duty_c
//  cfg          in   supply_volts (0), limit_volts (1)
//
//  One item per clock while the skid is empty; the pipeline runs through the
//  vectoring and rotation cell chains and the 16-step divider chain.
//  The pipeline moves as a whole; a one-entry skid behind the output register
//  keeps input flowing while a result waits. Stall only when the skid is full.
//  Reset clears valid flags and loads the default register values.
//
module space_vector_phase_duty import svpd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // volt_q [15:0], volt_d [31:16], elec_angle [47:32]
  input  logic [47:0]     s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // duty_a [15:0], duty_b [31:16], duty_c [47:32]
  output logic [47:0]     m_axis_tdata,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned Depth = 24 + 2 * CORDIC_STEPS;

  logic [CfgW-1:0] supply_q, limit_q;
  logic            en;
  logic [Depth-1:0] valid_q;

  item_t init_q, mul_q, sec_q, trig_q, tv_q, kv_q, prod_q, dinit_q;
  item_t vec [CORDIC_STEPS+1];
  item_t rot [CORDIC_STEPS+1];
  item_t dch [DivBits+1];

  logic        out_v_q, skid_v_q;
  logic [47:0] out_q, skid_q, duty_w;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SupplyRst;
      limit_q  <= LimitRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegSupply) begin
        supply_q <= cfg_data_i;
      end else begin
        limit_q <= cfg_data_i;
      end
    end
  end

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // valid flags follow the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // input capture and vectoring preload
  always_ff @(posedge clk_i) begin
    logic signed [15:0] vq, vd;
    logic signed [33:0] xq, xd;
    item_t              init_d;
    if (en) begin
      vq = $signed(s_axis_tdata[15:0]);
      vd = $signed(s_axis_tdata[31:16]);
      xq = 34'(vq) <<< 14;
      xd = 34'(vd) <<< 14;
      init_d        = '0;
      init_d.q      = vq;
      init_d.angle  = s_axis_tdata[47:32];
      init_d.simple = (vd == 16'sd0);
      init_d.cx     = vd[15] ? -xd : xd;
      init_d.cy     = vd[15] ? -xq : xq;
      init_d.cz     = vd[15] ? 33'sh0_8000_0000 : 33'sd0;
      init_q <= init_d;
    end
  end

  // vectoring chain: magnitude and angle of the command
  assign vec[0] = init_q;
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    svpd_cordic_cell #(.MODE(CORDIC_VECTOR), .STEP(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .item_i(vec[i]),
      .item_o(vec[i+1])
    );
  end

  // gain correction product and advanced angle
  always_ff @(posedge clk_i) begin
    logic [60:0] m;
    item_t       mul_d;
    if (en) begin
      m = vec[CORDIC_STEPS].cx[30:0] * InvkQ30;
      mul_d         = vec[CORDIC_STEPS];
      mul_d.prod[0] = 64'(m);
      mul_d.theta   = {vec[CORDIC_STEPS].angle, 16'b0} +
                      (vec[CORDIC_STEPS].simple ? 32'h4000_0000
                                                : vec[CORDIC_STEPS].cz[31:0]);
      mul_q <= mul_d;
    end
  end

  // magnitude rounding, sector and sector phase, rotation preload
  always_ff @(posedge clk_i) begin
    logic [63:0] rr;
    logic [34:0] six;
    logic [31:0] phi;
    item_t       sec_d;
    if (en) begin
      rr  = mul_q.prod[0] + 64'd536870912;
      six = {1'b0, mul_q.theta, 2'b0} + {2'b0, mul_q.theta, 1'b0};
      phi = mul_q.theta - SecBase[six[34:32]];
      sec_d     = mul_q;
      sec_d.r   = mul_q.simple ? (31'(mul_q.q) <<< 14) : $signed(rr[60:30]);
      sec_d.sec = six[34:32];
      sec_d.cx  = 34'(InvkQ30);
      sec_d.cy  = '0;
      sec_d.cz  = 33'(phi);
      sec_q <= sec_d;
    end
  end

  // rotation chain: cos and sin of the sector phase
  assign rot[0] = sec_q;
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    svpd_cordic_cell #(.MODE(CORDIC_ROTATE), .STEP(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .item_i(rot[i]),
      .item_o(rot[i+1])
    );
  end

  // cosine- and sine-weighted products
  always_ff @(posedge clk_i) begin
    logic signed [65:0] m0, m1, m2;
    item_t              trig_d;
    if (en) begin
      m0 = rot[CORDIC_STEPS].cx * ThreeHalvesQ30;
      m1 = rot[CORDIC_STEPS].cy * HalfSqrt3Q30;
      m2 = rot[CORDIC_STEPS].cy * Sqrt3Q30;
      trig_d         = rot[CORDIC_STEPS];
      trig_d.prod[0] = m0[63:0];
      trig_d.prod[1] = m1[63:0];
      trig_d.prod[2] = m2[63:0];
      trig_q <= trig_d;
    end
  end

  // t1 and t2, rounded to Q30
  always_ff @(posedge clk_i) begin
    logic signed [63:0] a1, a2, s1, s2;
    item_t              tv_d;
    if (en) begin
      a1 = $signed(trig_q.prod[0]) - $signed(trig_q.prod[1]) + 64'sd536870912;
      a2 = $signed(trig_q.prod[2]) + 64'sd536870912;
      s1 = a1 >>> 30;
      s2 = a2 >>> 30;
      tv_d      = trig_q;
      tv_d.k[0] = s1[33:0];
      tv_d.k[1] = s2[33:0];
      tv_q <= tv_d;
    end
  end

  // phase factors per sector, split into magnitude and sign
  always_ff @(posedge clk_i) begin
    logic signed [33:0] u, w, nu, nw;
    logic [31:0]        au, aw;
    logic [2:0]         use_w, flip;
    logic               su, sw, sr;
    item_t              kv_d;
    if (en) begin
      u  = $signed(tv_q.k[0]) + $signed(tv_q.k[1]);
      w  = $signed(tv_q.k[1]) - $signed(tv_q.k[0]);
      nu = -u;
      nw = -w;
      su = u[33];
      sw = w[33];
      au = su ? nu[31:0] : u[31:0];
      aw = sw ? nw[31:0] : w[31:0];
      sr = tv_q.r[30];
      // bit order: phase c, b, a
      unique case (tv_q.sec)
        3'd0:    begin use_w = 3'b010; flip = 3'b100; end
        3'd1:    begin use_w = 3'b001; flip = 3'b101; end
        3'd2:    begin use_w = 3'b100; flip = 3'b001; end
        3'd3:    begin use_w = 3'b010; flip = 3'b011; end
        3'd4:    begin use_w = 3'b001; flip = 3'b010; end
        default: begin use_w = 3'b100; flip = 3'b110; end
      endcase
      kv_d = tv_q;
      for (int p = 0; p < 3; p++) begin
        kv_d.k[p]   = 34'(use_w[p] ? aw : au);
        kv_d.neg[p] = (use_w[p] ? sw : su) ^ flip[p] ^ sr;
      end
      kv_d.r = sr ? -tv_q.r : tv_q.r;
      kv_q <= kv_d;
    end
  end

  // phase products |k| * |r|
  always_ff @(posedge clk_i) begin
    logic [61:0] m [3];
    item_t       prod_d;
    if (en) begin
      prod_d = kv_q;
      for (int p = 0; p < 3; p++) begin
        m[p] = kv_q.k[p][31:0] * kv_q.r[29:0];
        prod_d.prod[p] = 64'(m[p]);
      end
      prod_q <= prod_d;
    end
  end

  // divider preload: rounding offset, overflow test, bound lane
  always_ff @(posedge clk_i) begin
    logic [63:0] n [3];
    logic [34:0] a [3];
    logic [34:0] top;
    item_t       dinit_d;
    if (en) begin
      top = 35'({limit_q, 16'b0});
      dinit_d     = prod_q;
      dinit_d.quo = '0;
      for (int p = 0; p < 3; p++) begin
        n[p] = prod_q.prod[p] + (64'(limit_q) << 28);
        a[p] = n[p][63:29];
        dinit_d.rem[p] = a[p][RemW-1:0];
        dinit_d.ovf[p] = (a[p] >= top);
      end
      dinit_d.rem[3] = RemW'({limit_q, 16'b0});
      dinit_d.ovf[3] = (limit_q >= supply_q);
      dinit_q <= dinit_d;
    end
  end

  // divider chain, most significant quotient bit first
  assign dch[0] = dinit_q;
  for (genvar j = 0; j < DivBits; j++) begin : g_div
    svpd_div_cell #(.BIT(DivBits - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .limit_i (limit_q),
      .supply_i(supply_q),
      .item_i  (dch[j]),
      .item_o  (dch[j+1])
    );
  end

  function automatic logic [15:0] sat_mid(input logic ovf, input logic [15:0] q);
    return (ovf || q > DutyMid) ? DutyMid : q;
  endfunction

  // clamp to bound, offset by half and saturate
  always_comb begin
    logic [15:0] bnd, v;
    bnd = sat_mid(dch[DivBits].ovf[3], dch[DivBits].quo[3]);
    for (int p = 0; p < 3; p++) begin
      v = sat_mid(dch[DivBits].ovf[p], dch[DivBits].quo[p]);
      if (v > bnd) begin
        v = bnd;
      end
      if (supply_q == '0 || limit_q == '0) begin
        duty_w[16*p +: 16] = DutyMid;
      end else if (dch[DivBits].neg[p]) begin
        duty_w[16*p +: 16] = DutyMid - v;
      end else if (v == DutyMid) begin
        duty_w[16*p +: 16] = DutyMax;
      end else begin
        duty_w[16*p +: 16] = DutyMid + v;
      end
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        out_q    <= skid_q;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= valid_q[Depth-1];
      out_q   <= duty_w;
    end else if (valid_q[Depth-1]) begin
      skid_v_q <= 1'b1;
      skid_q   <= duty_w;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule
